/* src/hbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared constants for the heading pipeline: angle units, CORDIC table.
// ----------------------------------------------------------------------------
package hbc_pkg;

  localparam int Steps = 30;

  localparam logic signed [31:0] Deg90 = 32'sd900000000;
  localparam logic signed [31:0] Deg180 = 32'sd1800000000;
  localparam logic signed [33:0] Deg360 = 34'sd3600000000;
  localparam logic signed [31:0] InvGainQ30 = 32'sd652032874;
  localparam logic [16:0] UnitsPerCdeg = 17'd100000;

  function automatic logic signed [31:0] atan_units(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0: r = 32'sd450000000;
      5'd1: r = 32'sd265650512;
      5'd2: r = 32'sd140362435;
      5'd3: r = 32'sd71250163;
      5'd4: r = 32'sd35763344;
      5'd5: r = 32'sd17899106;
      5'd6: r = 32'sd8951737;
      5'd7: r = 32'sd4476142;
      5'd8: r = 32'sd2238105;
      5'd9: r = 32'sd1119057;
      5'd10: r = 32'sd559529;
      5'd11: r = 32'sd279765;
      5'd12: r = 32'sd139882;
      5'd13: r = 32'sd69941;
      5'd14: r = 32'sd34971;
      5'd15: r = 32'sd17485;
      5'd16: r = 32'sd8743;
      5'd17: r = 32'sd4371;
      5'd18: r = 32'sd2186;
      5'd19: r = 32'sd1093;
      5'd20: r = 32'sd546;
      5'd21: r = 32'sd273;
      5'd22: r = 32'sd137;
      5'd23: r = 32'sd68;
      5'd24: r = 32'sd34;
      5'd25: r = 32'sd17;
      5'd26: r = 32'sd9;
      5'd27: r = 32'sd4;
      5'd28: r = 32'sd2;
      5'd29: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // Special-case classification travelling beside the CORDIC data
  typedef enum logic [2:0] {
    CASE_GENERAL,
    CASE_ZERO,
    CASE_EAST,
    CASE_WEST,
    CASE_SOUTH
  } case_t;

endpackage

/* src/heading_between_coordinates_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_between_coordinates_top
// Flat-earth heading from a start point to an end point, in 0.01 degree.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one item: start and end
//   latitude/longitude in signed 1e-7 degree. The output channel
//   (out_valid/out_ready) returns one heading per item, clockwise from north,
//   0..35999 hundredths of a degree.
//   Inside, a stage prepares |lat1| folded to the first quadrant, then 30
//   CORDIC rotation stages give cos(lat1), one multiply stage forms the east
//   component, a fold stage turns north into the right half-plane, a
//   normalise stage scales (north, east), 30 CORDIC vectoring stages give the
//   angle and three final stages wrap it into one turn, divide and round it.
//   Depth: 67 register stages, from stage 0 to the output register.
//   Throughput: one item every cycle while the receiver does not stall;
//   each stage holds one item.
//   Stall: the whole pipeline advances only when the last stage is empty or
//   its item is being taken, so a stalled receiver holds every item in place
//   and nothing is lost or repeated. in_ready falls whenever the output holds
//   an item that the receiver does not take.
//   Reset: rst (synchronous) clears every valid bit; data need no reset.
// ----------------------------------------------------------------------------
module heading_between_coordinates_top
  import hbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [30:0] start_latitude,
  input  logic signed [31:0] start_longitude,
  input  logic signed [30:0] end_latitude,
  input  logic signed [31:0] end_longitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        heading_centidegrees
);

  // Stage counts
  localparam int NC = Steps;           // cosine stages
  localparam int NV = Steps;           // vectoring stages
  localparam int NS = NC + NV + 7;     // total stages

  logic [NS-1:0] vld;
  logic adv;

  // Advance when the output register is free or draining
  assign adv = !vld[NS-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: classify, differences, fold latitude
  // --------------------------------------------------------------------------
  case_t               s0_case;
  logic signed [31:0]  s0_dlat;
  logic signed [32:0]  s0_dlon;
  logic signed [31:0]  s0_z;
  logic                s0_neg;

  logic signed [31:0] lat_abs;
  logic               lat_big;
  case_t              cls;

  always_comb begin
    lat_abs = start_latitude[30] ? -32'(start_latitude) : 32'(start_latitude);
    lat_big = lat_abs > Deg90;
    if (start_latitude == end_latitude) begin
      if (end_longitude > start_longitude) begin
        cls = CASE_EAST;
      end else if (end_longitude < start_longitude) begin
        cls = CASE_WEST;
      end else begin
        cls = CASE_ZERO;
      end
    end else if (start_longitude == end_longitude) begin
      cls = (end_latitude > start_latitude) ? CASE_ZERO : CASE_SOUTH;
    end else begin
      cls = CASE_GENERAL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_case <= cls;
      s0_dlat <= 32'(end_latitude) - 32'(start_latitude);
      s0_dlon <= 33'(end_longitude) - 33'(start_longitude);
      s0_z    <= lat_big ? Deg180 - lat_abs : lat_abs;
      s0_neg  <= lat_big;
    end
  end

  // --------------------------------------------------------------------------
  // Cosine CORDIC rotation stages
  // --------------------------------------------------------------------------
  logic signed [31:0] cx [NC+1];
  logic signed [31:0] cy [NC+1];
  logic signed [32:0] cz [NC+1];
  case_t              ccase [NC+1];
  logic signed [31:0] cdlat [NC+1];
  logic signed [32:0] cdlon [NC+1];
  logic               cneg [NC+1];

  assign cx[0] = InvGainQ30;
  assign cy[0] = '0;
  assign cz[0] = 33'(s0_z);
  assign ccase[0] = s0_case;
  assign cdlat[0] = s0_dlat;
  assign cdlon[0] = s0_dlon;
  assign cneg[0] = s0_neg;

  for (genvar i = 0; i < NC; i++) begin : g_cos
    logic signed [31:0] dx, dy;
    logic signed [32:0] at;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    assign at = 33'(atan_units(5'(i)));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cz[i][32]) begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - at;
        end else begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + at;
        end
        ccase[i+1] <= ccase[i];
        cdlat[i+1] <= cdlat[i];
        cdlon[i+1] <= cdlon[i];
        cneg[i+1]  <= cneg[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Multiply stage: east = floor(cos * dlon / 2^30)
  // --------------------------------------------------------------------------
  case_t              m_case;
  logic signed [31:0] m_dlat;
  logic signed [65:0] m_prod;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_case <= ccase[NC];
      m_dlat <= cdlat[NC];
      m_prod <= 66'(cneg[NC] ? -33'(cx[NC]) : 33'(cx[NC])) * 66'(cdlon[NC]);
    end
  end

  // --------------------------------------------------------------------------
  // Half-plane fold stage: negate when north < 0
  // --------------------------------------------------------------------------
  case_t              f_case;
  logic signed [41:0] f_x;
  logic signed [41:0] f_y;
  logic               f_half;
  logic signed [41:0] east_w;

  assign east_w = 42'(m_prod >>> 30);

  always_ff @(posedge clk) begin
    if (adv) begin
      f_case <= m_case;
      f_half <= m_dlat[31];
      f_x    <= m_dlat[31] ? -42'(m_dlat) : 42'(m_dlat);
      f_y    <= m_dlat[31] ? -east_w : east_w;
    end
  end

  // --------------------------------------------------------------------------
  // Normalise stage: double until a component reaches 2^39
  // --------------------------------------------------------------------------
  case_t              n_case;
  logic               n_half;
  logic signed [41:0] n_x;
  logic signed [41:0] n_y;
  logic [5:0]         sh;
  logic [40:0]        ay;
  logic [40:0]        orv;

  always_comb begin
    ay  = f_y[41] ? 41'(-f_y) : 41'(f_y);
    orv = 41'(f_x) | ay;
    sh  = '0;
    // Count leading zeros above bit 39; magnitudes are known below 2^40
    for (int b = 0; b < 40; b++) begin
      if (orv[b]) begin
        sh = 6'(39 - b);
      end
    end
    if (orv[40] || orv[39]) begin
      sh = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_case <= f_case;
      n_half <= f_half;
      n_x    <= f_x <<< sh;
      n_y    <= f_y <<< sh;
    end
  end

  // --------------------------------------------------------------------------
  // Vectoring CORDIC stages
  // --------------------------------------------------------------------------
  logic signed [42:0] vx [NV+1];
  logic signed [42:0] vy [NV+1];
  logic signed [32:0] vz [NV+1];
  case_t              vcase [NV+1];
  logic               vhalf [NV+1];

  assign vx[0] = 43'(n_x);
  assign vy[0] = 43'(n_y);
  assign vz[0] = '0;
  assign vcase[0] = n_case;
  assign vhalf[0] = n_half;

  for (genvar i = 0; i < NV; i++) begin : g_vec
    logic signed [42:0] dx, dy;
    logic signed [32:0] at;
    assign dx = vy[i] >>> i;
    assign dy = vx[i] >>> i;
    assign at = 33'(atan_units(5'(i)));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (vy[i][42]) begin
          vx[i+1] <= vx[i] - dx;
          vy[i+1] <= vy[i] + dy;
          vz[i+1] <= vz[i] - at;
        end else begin
          vx[i+1] <= vx[i] + dx;
          vy[i+1] <= vy[i] - dy;
          vz[i+1] <= vz[i] + at;
        end
        vcase[i+1] <= vcase[i];
        vhalf[i+1] <= vhalf[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Wrap stage: base + z into [0, 360 degrees)
  // --------------------------------------------------------------------------
  case_t              w_case;
  logic [31:0]        w_h;
  logic signed [33:0] h_raw;

  always_comb begin
    h_raw = 34'(vz[NV]) + (vhalf[NV] ? 34'(Deg180) : 34'sd0);
    if (h_raw < 0) begin
      h_raw = h_raw + Deg360;
    end else if (h_raw >= Deg360) begin
      h_raw = h_raw - Deg360;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_case <= vcase[NV];
      w_h    <= 32'(h_raw);
    end
  end

  // --------------------------------------------------------------------------
  // Quotient stage: estimate floor((h + 50000) / 100000) by reciprocal
  // --------------------------------------------------------------------------
  case_t       q_case;
  logic [31:0] q_hr;
  logic [15:0] q_est;
  logic [31:0] hr;
  logic [63:0] qprod;

  always_comb begin
    hr    = w_h + 32'(UnitsPerCdeg >> 1);
    // ~2^48 / 100000, so the estimate is exact or one short
    qprod = 64'(hr) * 64'd2814749767;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_case <= w_case;
      q_hr   <= hr;
      q_est  <= 16'(qprod >> 48);
    end
  end

  // --------------------------------------------------------------------------
  // Round stage: correct the estimate by one compare, give the fixed heading of a special case, wrap 36000 to 0
  // --------------------------------------------------------------------------
  logic [32:0] rem;
  logic [15:0] qf;
  logic [15:0] res;

  always_comb begin
    rem   = 33'(q_hr) - 33'(q_est) * 33'(UnitsPerCdeg);
    qf    = (rem >= 33'(UnitsPerCdeg)) ? q_est + 16'd1 : q_est;
    if (qf >= 16'd36000) begin
      qf = qf - 16'd36000;
    end
    case (q_case)
      CASE_ZERO:  res = 16'd0;
      CASE_EAST:  res = 16'd9000;
      CASE_WEST:  res = 16'd27000;
      CASE_SOUTH: res = 16'd18000;
      default:    res = qf;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      heading_centidegrees <= res;
    end
  end

endmodule

/* bench/tb_heading_between_coordinates_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heading_between_coordinates_top
// Self-checking bench for the flat-earth heading pipeline.
//
// A queue of coordinate pairs feeds a clocked driver. Every accepted pair is
// run through a local fixed-point model of the heading, and the model's
// answer waits in a queue. A clocked monitor stalls the output at random and
// compares each returned heading with the oldest waiting answer.
// ----------------------------------------------------------------------------
module tb_heading_between_coordinates_top;
  import hbc_pkg::*;

  localparam int     NumRandom   = 1950;
  localparam int     PauseAt     = 900;
  localparam longint CycleLimit  = 800000;
  localparam longint NormLimit   = 64'sd1 << 39;
  localparam longint Turn        = 64'sd3600000000;

  typedef struct {
    logic signed [30:0] lat1;
    logic signed [31:0] lon1;
    logic signed [30:0] lat2;
    logic signed [31:0] lon2;
  } pair_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [30:0] start_latitude;
  logic signed [31:0] start_longitude;
  logic signed [30:0] end_latitude;
  logic signed [31:0] end_longitude;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        heading_centidegrees;

  pair_t       pair_q[$];
  logic [15:0] heading_q[$];
  int          n_errors;
  int          n_sent;
  int          send_gap;
  int          recv_gap;
  longint      cycles;

  heading_between_coordinates_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .start_latitude(start_latitude),
    .start_longitude(start_longitude),
    .end_latitude(end_latitude),
    .end_longitude(end_longitude),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .heading_centidegrees(heading_centidegrees)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // CORDIC arctangent step in 1e-7 degree; the table is our own copy
  function automatic longint atan_step(input int i);
    longint tbl[30] = '{450000000, 265650512, 140362435, 71250163, 35763344,
                        17899106, 8951737, 4476142, 2238105, 1119057, 559529,
                        279765, 139882, 69941, 34971, 17485, 8743, 4371, 2186,
                        1093, 546, 273, 137, 68, 34, 17, 9, 4, 2, 1};
    return tbl[i];
  endfunction

  // Cosine in Q30 by 30 rotation steps; beyond 90 degrees fold and negate
  function automatic longint cos_q30(input longint ang);
    longint a;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit     neg;
    a = (ang < 0) ? -ang : ang;
    neg = 1'b0;
    if (a > 64'sd900000000) begin
      a = 64'sd1800000000 - a;
      neg = 1'b1;
    end
    x = 64'sd652032874;
    y = 0;
    z = a;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    return neg ? -x : x;
  endfunction

  // Angle of (north, east) clockwise from north, folded into one turn
  function automatic longint bearing_units(input longint north, input longint east);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint h;
    x = north;
    y = east;
    z = 0;
    h = 0;
    if (x < 0) begin
      x = -x; y = -y; h = 64'sd1800000000;
    end
    while (x < NormLimit && ((y < 0) ? -y : y) < NormLimit) begin
      x = x * 2; y = y * 2;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    h = h + z;
    while (h < 0) h += Turn;
    while (h >= Turn) h -= Turn;
    return h;
  endfunction

  function automatic logic [15:0] heading_of(input pair_t p);
    longint lat1;
    longint lon1;
    longint lat2;
    longint lon2;
    longint east;
    longint r;
    lat1 = p.lat1;
    lon1 = p.lon1;
    lat2 = p.lat2;
    lon2 = p.lon2;
    if (lat1 == lat2) begin
      r = (lon2 > lon1) ? 9000 : ((lon2 < lon1) ? 27000 : 0);
    end else if (lon1 == lon2) begin
      r = (lat2 > lat1) ? 0 : 18000;
    end else begin
      east = (cos_q30(lat1) * (lon2 - lon1)) >>> 30;
      r = (bearing_units(lat2 - lat1, east) + 50000) / 100000;
      if (r >= 36000) r -= 36000;
    end
    return r[15:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint in_lat();
    return longint'($urandom_range(0, 1800000000)) - 900000000;
  endfunction

  function automatic longint in_lon();
    return longint'($urandom_range(0, 3600000000)) - 1800000000;
  endfunction

  task automatic add_pair(input longint a, input longint b, input longint c,
                          input longint d);
    pair_t p;
    p.lat1 = a[30:0];
    p.lon1 = b[31:0];
    p.lat2 = c[30:0];
    p.lon2 = d[31:0];
    pair_q.push_back(p);
  endtask

  task automatic report_mismatch(input logic [15:0] got, input logic [15:0] want);
    n_errors++;
    $display("tb: heading mismatch at cycle %0d: got %0d, want %0d", cycles, got, want);
  endtask

  // Driver: hold the item until accepted, then advance or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        heading_q.push_back(heading_of('{start_latitude, start_longitude,
                                          end_latitude, end_longitude}));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pair_q.size() > 0 && !(n_sent == PauseAt && heading_q.size() > 0)) begin
          start_latitude  <= pair_q[0].lat1;
          start_longitude <= pair_q[0].lon1;
          end_latitude    <= pair_q[0].lat2;
          end_longitude   <= pair_q[0].lon2;
          void'(pair_q.pop_front());
          in_valid <= 1'b1;
          // quiet stretches keep the pipe saturated now and then
          send_gap <= ((n_sent / 150) % 3 == 1) ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the receiver at random, check every returned heading
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end else if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (heading_q.size() == 0) begin
          report_mismatch(heading_centidegrees, 16'hxxxx);
        end else begin
          if (heading_centidegrees !== heading_q[0])
            report_mismatch(heading_centidegrees, heading_q[0]);
          void'(heading_q.pop_front());
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap <= ((cycles / 1000) % 4 == 2) ? 0 : pick_gap();
      end
    end
  end

  initial begin
    longint a;
    longint b;
    int     k;
    int     n_total;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    start_latitude = '0;
    start_longitude = '0;
    end_latitude = '0;
    end_longitude = '0;
    n_errors = 0;
    n_sent = 0;
    send_gap = 0;
    recv_gap = 0;
    cycles = 0;

    // directed: identical points, same latitude, same longitude, extremes
    add_pair(0, 0, 0, 0);
    add_pair(100, 5, 100, 6);
    add_pair(100, 6, 100, 5);
    add_pair(-5, 7, 3, 7);
    add_pair(3, 7, -5, 7);
    add_pair(-900000000, -1800000000, 900000000, 1800000000);
    add_pair(900000000, 1800000000, -900000000, -1800000000);
    add_pair(900000000, -1800000000, -900000000, 1800000000);
    add_pair(0, 0, 1, 1);
    add_pair(0, 0, -1, -1);
    add_pair(0, 0, 1, -1);
    add_pair(0, 0, -1, 1);
    add_pair(899999999, 0, 900000000, 1);
    // latitude beyond 90 degrees: negative cosine
    add_pair(1073741823, 10, 0, 20);
    add_pair(-1073741824, 10, 0, -20);
    // longitude difference beyond a full turn, no wrap
    add_pair(0, -2147483648, 1000, 2147483647);
    add_pair(0, 2147483647, -1000, -2147483648);
    add_pair(-1073741824, -2147483648, 1073741823, 2147483647);
    add_pair(450000000, 0, 450000001, 900000000);
    add_pair(0, 0, 1800000, 1);
    add_pair(0, 0, 1, 1800000);

    for (int n = 0; n < NumRandom; n++) begin
      k = $urandom_range(0, 99);
      a = in_lat();
      b = in_lon();
      if (k < 10) begin
        add_pair(longint'(int'($urandom)), longint'(int'($urandom)),
                 longint'(int'($urandom)), longint'(int'($urandom)));
      end else if (k < 40) begin
        add_pair(a, b, in_lat(), in_lon());
      end else if (k < 70) begin
        add_pair(a, b, a + $urandom_range(0, 2000) - 1000, b + $urandom_range(0, 2000) - 1000);
      end else if (k < 80) begin
        add_pair(a, b, a, in_lon());
      end else if (k < 90) begin
        add_pair(a, b, in_lat(), b);
      end else begin
        add_pair(a, b, a + $urandom_range(0, 200000000) - 100000000,
                 b + $urandom_range(0, 200000000) - 100000000);
      end
    end
    n_total = pair_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // wait for every item to be taken and every heading to return, then
    // hold on a while to catch anything extra
    while (n_sent < n_total || heading_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
